>>> design/first_fit_segment_allocator_unit_defines.svh
// Assertion macros shared by the checker of the allocator.
`ifndef FIRST_FIT_SEGMENT_ALLOCATOR_UNIT_DEFINES_SVH
`define FIRST_FIT_SEGMENT_ALLOCATOR_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define FFSA_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("allocator check failed");

// Next-cycle implication, disabled while reset is asserted.
`define FFSA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("allocator check failed");

`endif

>>> design/ffsa_pkg.sv
package ffsa_pkg;

  // Field widths of the pool offset and the segment length.
  localparam int OFF_W = 20;
  localparam int LEN_W = 21;
  localparam int MARGIN_W = 16;
  localparam logic [MARGIN_W-1:0] MARGIN_RESET = 16'd64;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NOMEM   = 2'd1,
    ST_BADADDR = 2'd2,
    ST_ZERO    = 2'd3
  } status_t;

  // Operation codes of the mode field.
  localparam logic MODE_ALLOC = 1'b0;
  localparam logic MODE_FREE  = 1'b1;

  // Contents of one table cell.
  typedef struct packed {
    logic             valid;
    logic             free;
    logic [OFF_W-1:0] offset;
    logic [LEN_W-1:0] length;
  } seg_t;

  // Controls broadcast from the sequencer to every cell.
  typedef struct packed {
    logic             cmp_en;
    logic             commit;
    logic             free_op;
    logic             split;
    logic [LEN_W-1:0] size;
    logic [OFF_W-1:0] addr;
    logic [LEN_W:0]   need;
  } cell_ctl_t;

endpackage

>>> design/ffsa_if.sv
// Request channel: one allocate or free item.
interface ffsa_in_if;
  logic                           valid;
  logic                           ready;
  logic                           mode;
  logic [ffsa_pkg::LEN_W-1:0]     request_size;
  logic [ffsa_pkg::OFF_W-1:0]     block_address;

  modport source (output valid, mode, request_size, block_address, input ready);
  modport sink (input valid, mode, request_size, block_address, output ready);
endinterface

// Result channel: one result item per request.
interface ffsa_out_if;
  logic                           valid;
  logic                           ready;
  logic [1:0]                     status;
  logic [ffsa_pkg::OFF_W-1:0]     granted_address;
  logic [ffsa_pkg::LEN_W-1:0]     granted_size;

  modport source (output valid, status, granted_address, granted_size, input ready);
  modport sink (input valid, status, granted_address, granted_size, output ready);
endinterface

>>> design/ffsa_cell.sv
// One table entry. It compares itself against the request, and on commit
// either updates itself, takes the remainder from its left neighbor, or
// takes the left neighbor's contents when the table opens up for a split.
module ffsa_cell #(
  parameter logic [20:0] RESET_LEN = 21'd0
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  ffsa_pkg::cell_ctl_t   ctl,
  input  ffsa_pkg::seg_t        left_seg,
  input  ffsa_pkg::seg_t        left_rest,
  input  logic                  left_sel,
  input  logic                  before_in,
  output ffsa_pkg::seg_t        seg_o,
  output ffsa_pkg::seg_t        rest_o,
  output logic                  sel_o,
  output logic                  before_o,
  output logic                  fit_sel_o
);

  ffsa_pkg::seg_t seg_r, seg_nxt;
  logic hit_r, hit_nxt;
  logic fit_r, fit_nxt;

  // First hit in the chain selects this cell.
  assign sel_o     = hit_r & ~before_in;
  assign before_o  = before_in | hit_r;
  assign fit_sel_o = sel_o & fit_r;
  assign seg_o     = seg_r;

  // Free remainder handed to the right neighbor when this cell splits.
  always_comb begin
    rest_o        = '0;
    rest_o.valid  = 1'b1;
    rest_o.free   = 1'b1;
    rest_o.offset = ffsa_pkg::OFF_W'(seg_r.offset + ctl.size[ffsa_pkg::OFF_W-1:0]);
    rest_o.length = seg_r.length - ctl.size;
  end

  // Compare while cmp_en is set, update on commit.
  always_comb begin
    seg_nxt = seg_r;
    hit_nxt = hit_r;
    fit_nxt = fit_r;
    if (ctl.cmp_en) begin
      if (ctl.free_op) begin
        hit_nxt = seg_r.valid & (seg_r.offset == ctl.addr);
      end else begin
        hit_nxt = seg_r.valid & seg_r.free & (seg_r.length >= ctl.size);
      end
      fit_nxt = ({1'b0, seg_r.length} >= ctl.need) && (seg_r.length > ctl.size);
    end
    if (ctl.commit) begin
      if (sel_o) begin
        if (ctl.free_op) begin
          seg_nxt.free = 1'b1;
        end else begin
          seg_nxt.free = 1'b0;
          if (ctl.split) begin
            seg_nxt.length = ctl.size;
          end
        end
      end else if (ctl.split && before_in) begin
        seg_nxt = left_sel ? left_rest : left_seg;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seg_r.valid  <= (RESET_LEN != '0);
      seg_r.free   <= (RESET_LEN != '0);
      seg_r.offset <= '0;
      seg_r.length <= RESET_LEN;
      hit_r        <= 1'b0;
      fit_r        <= 1'b0;
    end else begin
      seg_r <= seg_nxt;
      hit_r <= hit_nxt;
      fit_r <= fit_nxt;
    end
  end

endmodule

>>> design/first_fit_segment_allocator_unit.sv
// An accepted item passes through the compare state, then the update state of the cell row;
// the update state loads its result into the output register.
// The next item is taken in the update cycle; a stalled result holds the update.
// Reset (synchronous, rst_n low): one free segment spans the pool, split margin 64,
// no result pending.
module first_fit_segment_allocator_unit #(
  parameter int POOL_BYTES   = 1048576,
  parameter int MAX_SEGMENTS = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  ffsa_in_if.sink            in_chan,
  ffsa_out_if.source         out_chan,
  input  logic               cfg_we,
  input  logic [15:0]        cfg_wdata
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_CMP  = 3'b010,
    S_UPD  = 3'b100
  } state_t;

  state_t state_r, state_nxt;

  logic                             req_mode_r;
  logic [ffsa_pkg::LEN_W-1:0]       req_size_r;
  logic [ffsa_pkg::OFF_W-1:0]       req_addr_r;
  logic [ffsa_pkg::MARGIN_W-1:0]    margin_r;

  logic                             out_valid_r;
  ffsa_pkg::status_t                out_status_r, out_status_nxt;
  logic [ffsa_pkg::OFF_W-1:0]       out_addr_r, out_addr_nxt;
  logic [ffsa_pkg::LEN_W-1:0]       out_size_r, out_size_nxt;

  ffsa_pkg::cell_ctl_t              ctl;
  ffsa_pkg::seg_t                   seg_w  [MAX_SEGMENTS];
  ffsa_pkg::seg_t                   rest_w [MAX_SEGMENTS];
  logic [MAX_SEGMENTS-1:0]          sel_w;
  logic [MAX_SEGMENTS-1:0]          fit_sel_w;
  logic [MAX_SEGMENTS:0]            before_w;

  logic                             out_free;
  logic                             in_acc;
  logic                             zero_req;
  logic                             found;
  logic                             split;
  logic [ffsa_pkg::OFF_W-1:0]       sel_off;
  logic [ffsa_pkg::LEN_W-1:0]       sel_len;

  // Handshake.
  assign out_free       = ~out_valid_r | out_chan.ready;
  assign in_chan.ready  = (state_r == S_IDLE) | ((state_r == S_UPD) & out_free);
  assign in_acc         = in_chan.valid & in_chan.ready;
  assign out_chan.valid = out_valid_r;
  assign out_chan.status          = out_status_r;
  assign out_chan.granted_address = out_addr_r;
  assign out_chan.granted_size    = out_size_r;

  assign zero_req = (req_mode_r == ffsa_pkg::MODE_ALLOC) && (req_size_r == '0);
  assign found    = before_w[MAX_SEGMENTS];

  // Split only for an allocation that fits with margin, while the table has room.
  assign split = (req_mode_r == ffsa_pkg::MODE_ALLOC) & (|fit_sel_w)
               & ~seg_w[MAX_SEGMENTS-1].valid;

  // Broadcast controls for the cell row.
  always_comb begin
    ctl         = '0;
    ctl.cmp_en  = (state_r == S_CMP);
    ctl.commit  = (state_r == S_UPD) & out_free & ~zero_req;
    ctl.free_op = (req_mode_r == ffsa_pkg::MODE_FREE);
    ctl.split   = split;
    ctl.size    = req_size_r;
    ctl.addr    = req_addr_r;
    ctl.need    = {1'b0, req_size_r} + (ffsa_pkg::LEN_W + 1)'(margin_r);
  end

  // Row of cells; each one sees only its left neighbor.
  assign before_w[0] = 1'b0;
  for (genvar k = 0; k < MAX_SEGMENTS; k++) begin : g_cell
    ffsa_pkg::seg_t left_seg;
    ffsa_pkg::seg_t left_rest;
    logic           left_sel;
    if (k == 0) begin : g_head
      assign left_seg  = '0;
      assign left_rest = '0;
      assign left_sel  = 1'b0;
    end else begin : g_body
      assign left_seg  = seg_w[k-1];
      assign left_rest = rest_w[k-1];
      assign left_sel  = sel_w[k-1];
    end
    ffsa_cell #(
      .RESET_LEN((k == 0) ? ffsa_pkg::LEN_W'(POOL_BYTES) : '0)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctl       (ctl),
      .left_seg  (left_seg),
      .left_rest (left_rest),
      .left_sel  (left_sel),
      .before_in (before_w[k]),
      .seg_o     (seg_w[k]),
      .rest_o    (rest_w[k]),
      .sel_o     (sel_w[k]),
      .before_o  (before_w[k+1]),
      .fit_sel_o (fit_sel_w[k])
    );
  end

  // Gather the selected segment; at most one cell is selected.
  always_comb begin
    sel_off = '0;
    sel_len = '0;
    for (int k = 0; k < MAX_SEGMENTS; k++) begin
      sel_off = sel_off | (seg_w[k].offset & {ffsa_pkg::OFF_W{sel_w[k]}});
      sel_len = sel_len | (seg_w[k].length & {ffsa_pkg::LEN_W{sel_w[k]}});
    end
  end

  // Result of the item in its update cycle.
  always_comb begin
    out_status_nxt = ffsa_pkg::ST_OK;
    out_addr_nxt   = '0;
    out_size_nxt   = '0;
    if (zero_req) begin
      out_status_nxt = ffsa_pkg::ST_ZERO;
    end else if (!found) begin
      out_status_nxt = (req_mode_r == ffsa_pkg::MODE_FREE) ? ffsa_pkg::ST_BADADDR
                                                           : ffsa_pkg::ST_NOMEM;
    end else if (req_mode_r == ffsa_pkg::MODE_ALLOC) begin
      out_addr_nxt = sel_off;
      out_size_nxt = split ? req_size_r : sel_len;
    end
  end

  // Sequencer.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc) state_nxt = S_CMP;
      end
      S_CMP: begin
        state_nxt = S_UPD;
      end
      S_UPD: begin
        if (out_free) state_nxt = in_acc ? S_CMP : S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      margin_r    <= ffsa_pkg::MARGIN_RESET;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) margin_r <= cfg_wdata;
      if ((state_r == S_UPD) && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      req_mode_r <= in_chan.mode;
      req_size_r <= in_chan.request_size;
      req_addr_r <= in_chan.block_address;
    end
    if ((state_r == S_UPD) && out_free) begin
      out_status_r <= out_status_nxt;
      out_addr_r   <= out_addr_nxt;
      out_size_r   <= out_size_nxt;
    end
  end

endmodule

>>> design/ffsa_checker.sv
`include "first_fit_segment_allocator_unit_defines.svh"

// Port-level checks on the allocator.
module ffsa_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  out_status,
  input logic [19:0] out_granted_address,
  input logic [20:0] out_granted_size
);

  // A waiting result item stays until it is taken.
  `FFSA_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid)

  // Items need a compare cycle, so no item is taken right after another.
  `FFSA_ASSERT_NEXT(a_no_back_to_back, clk, rst_n, in_valid && in_ready, !in_ready)

  // Failed items carry neither an address nor a size.
  `FFSA_ASSERT_NOW(a_fail_zero, clk, rst_n, out_valid && (out_status != ffsa_pkg::ST_OK), (out_granted_address == '0) && (out_granted_size == '0))

  // A granted address beyond the pool start always comes with a size.
  `FFSA_ASSERT_NOW(a_addr_has_size, clk, rst_n, out_valid && (out_granted_address != '0), out_granted_size != '0)

endmodule

bind first_fit_segment_allocator_unit ffsa_checker u_ffsa_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .in_valid            (in_chan.valid),
  .in_ready            (in_chan.ready),
  .out_valid           (out_chan.valid),
  .out_ready           (out_chan.ready),
  .out_status          (out_chan.status),
  .out_granted_address (out_chan.granted_address),
  .out_granted_size    (out_chan.granted_size)
);

>>> bench/first_fit_segment_allocator_unit_tb.sv
module first_fit_segment_allocator_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int POOL_SIZE = 1048576;
  localparam int MAX_SEGS = 64;
  localparam int STALL_LIMIT = 4000;
  localparam int SETTLE_CYCLES = 4;
  localparam int PHASE_ITEMS = 206;

  // One request item and one result item as they cross the channels.
  typedef struct packed {
    logic                           mode;
    logic [ffsa_pkg::LEN_W-1:0]     size;
    logic [ffsa_pkg::OFF_W-1:0]     addr;
  } seg_request_t;

  typedef struct packed {
    ffsa_pkg::status_t              status;
    logic [ffsa_pkg::OFF_W-1:0]     addr;
    logic [ffsa_pkg::LEN_W-1:0]     size;
  } seg_reply_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [15:0] cfg_wdata;

  ffsa_in_if in_if ();
  ffsa_out_if out_if ();

  first_fit_segment_allocator_unit #(
    .POOL_BYTES(POOL_SIZE),
    .MAX_SEGMENTS(MAX_SEGS)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_chan(in_if),
    .out_chan(out_if),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  // Shadow copy of the segment table and the split margin.
  logic [ffsa_pkg::OFF_W-1:0]    seg_off [MAX_SEGS];
  logic [ffsa_pkg::LEN_W-1:0]    seg_len [MAX_SEGS];
  bit                            seg_free [MAX_SEGS];
  int                            seg_count;
  logic [ffsa_pkg::MARGIN_W-1:0] split_margin_q;

  seg_request_t pending_requests[$];
  seg_reply_t   owed_replies[$];

  int  mismatches;
  int  idle_cycles;
  int  send_idle_pct;
  int  recv_stall_pct;
  logic in_taken;

  always #1 clk = ~clk;

  task automatic flag_mismatch(input string what);
    $display("mismatch at %0t ns: %s", $time, what);
    mismatches++;
  endtask

  function automatic void reset_table();
    for (int i = 0; i < MAX_SEGS; i++) begin
      seg_off[i] = '0;
      seg_len[i] = '0;
      seg_free[i] = 1'b0;
    end
    seg_len[0] = ffsa_pkg::LEN_W'(POOL_SIZE);
    seg_free[0] = 1'b1;
    seg_count = 1;
    split_margin_q = ffsa_pkg::MARGIN_RESET;
  endfunction

  // Applies one request to the shadow table and returns the reply it earns.
  function automatic seg_reply_t apply_segment_request(seg_request_t r);
    seg_reply_t rep;
    int hit;
    int unsigned len;
    int unsigned rest;
    int unsigned need;
    rep.status = ffsa_pkg::ST_OK;
    rep.addr = '0;
    rep.size = '0;
    hit = -1;
    if (r.mode == ffsa_pkg::MODE_FREE) begin
      for (int i = 0; i < seg_count; i++)
        if (hit < 0 && seg_off[i] == r.addr) hit = i;
      if (hit < 0) rep.status = ffsa_pkg::ST_BADADDR;
      else seg_free[hit] = 1'b1;
    end else if (r.size == '0) begin
      rep.status = ffsa_pkg::ST_ZERO;
    end else begin
      // First fit: lowest free segment that holds the request.
      for (int i = 0; i < seg_count; i++)
        if (hit < 0 && seg_free[i] && seg_len[i] >= r.size) hit = i;
      if (hit < 0) begin
        rep.status = ffsa_pkg::ST_NOMEM;
      end else begin
        len = 32'(seg_len[hit]);
        rest = len - 32'(r.size);
        need = 32'(r.size) + 32'(split_margin_q);
        // Split only with enough leftover and a spare row in the table.
        if (len >= need && rest > 0 && seg_count < MAX_SEGS) begin
          for (int k = seg_count; k > hit + 1; k--) begin
            seg_off[k] = seg_off[k-1];
            seg_len[k] = seg_len[k-1];
            seg_free[k] = seg_free[k-1];
          end
          seg_off[hit+1] = seg_off[hit] + r.size[ffsa_pkg::OFF_W-1:0];
          seg_len[hit+1] = ffsa_pkg::LEN_W'(rest);
          seg_free[hit+1] = 1'b1;
          seg_len[hit] = r.size;
          seg_count++;
        end
        seg_free[hit] = 1'b0;
        rep.addr = seg_off[hit];
        rep.size = seg_len[hit];
      end
    end
    return rep;
  endfunction

  // Sender: offers the next pending item, holding it until it is taken.
  always @(negedge clk) begin
    seg_request_t nxt;
    if (!rst_n) begin
      in_if.valid <= 1'b0;
    end else if (!in_if.valid || in_taken) begin
      if (pending_requests.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        nxt = pending_requests.pop_front();
        in_if.valid <= 1'b1;
        in_if.mode <= nxt.mode;
        in_if.request_size <= nxt.size;
        in_if.block_address <= nxt.addr;
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // Receiver: random back-pressure on the result channel.
  always @(negedge clk) begin
    out_if.ready <= rst_n && ($urandom_range(99) >= recv_stall_pct);
  end

  // Monitor: checks each result item, predicts each accepted request item.
  always @(posedge clk) begin
    seg_reply_t want;
    seg_request_t req;
    if (!rst_n) begin
      in_taken <= 1'b0;
      idle_cycles = 0;
    end else begin
      if (cfg_we) split_margin_q = cfg_wdata;
      if (out_if.valid === 1'b1 && out_if.ready) begin
        if (owed_replies.size() == 0) begin
          flag_mismatch("result item with no request outstanding");
        end else begin
          want = owed_replies.pop_front();
          if (out_if.status !== want.status)
            flag_mismatch($sformatf("status %0d, wanted %s", out_if.status, want.status.name()));
          if (out_if.granted_address !== want.addr)
            flag_mismatch($sformatf("granted_address 0x%05h, wanted 0x%05h",
                                    out_if.granted_address, want.addr));
          if (out_if.granted_size !== want.size)
            flag_mismatch($sformatf("granted_size %0d, wanted %0d",
                                    out_if.granted_size, want.size));
        end
      end
      if (in_if.valid && in_if.ready) begin
        req.mode = in_if.mode;
        req.size = in_if.request_size;
        req.addr = in_if.block_address;
        owed_replies.push_back(apply_segment_request(req));
      end
      in_taken <= in_if.valid && in_if.ready;

      // Watchdog on cycles in which neither channel moves an item.
      if ((in_if.valid && in_if.ready) || (out_if.valid === 1'b1 && out_if.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  task automatic queue_request(input logic mode, input int size, input int addr);
    seg_request_t r;
    r.mode = mode;
    r.size = ffsa_pkg::LEN_W'(size);
    r.addr = ffsa_pkg::OFF_W'(addr);
    pending_requests.push_back(r);
  endtask

  // Mostly allocations and frees of live offsets; a little noise.
  function automatic seg_request_t random_request();
    seg_request_t r;
    int roll;
    int band;
    roll = $urandom_range(99);
    r.mode = ffsa_pkg::MODE_ALLOC;
    r.size = ffsa_pkg::LEN_W'($urandom_range(POOL_SIZE));
    r.addr = ffsa_pkg::OFF_W'($urandom);
    if (roll < 52) begin
      band = $urandom_range(9);
      case (band)
        0, 1, 2, 3: r.size = ffsa_pkg::LEN_W'($urandom_range(256, 1));
        4, 5:       r.size = ffsa_pkg::LEN_W'($urandom_range(16384, 257));
        6, 7:       r.size = ffsa_pkg::LEN_W'($urandom_range(131072, 16385));
        8:          r.size = ffsa_pkg::LEN_W'($urandom_range(POOL_SIZE, 131073));
        default:    r.size = seg_len[$urandom_range(seg_count - 1)];
      endcase
      if (r.size == '0) r.size = 1;
    end else if (roll < 92) begin
      r.mode = ffsa_pkg::MODE_FREE;
      r.addr = seg_off[$urandom_range(seg_count - 1)];
    end else if (roll < 95) begin
      r.size = '0;
    end else begin
      r.mode = ffsa_pkg::MODE_FREE;
    end
    return r;
  endfunction

  task automatic queue_random(input int count);
    int made;
    made = 0;
    while (made < count) begin
      if (pending_requests.size() < 8) begin
        pending_requests.push_back(random_request());
        made++;
      end else begin
        @(negedge clk);
      end
    end
  endtask

  // Waits until every item is taken and answered, then lets the block settle.
  // The wait is polled at the rising edge, where the sender is quiet.
  task automatic drain();
    while (pending_requests.size() != 0 || in_if.valid || owed_replies.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_margin(input logic [15:0] value);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic run_phase(input logic [15:0] margin, input int send_pct, input int recv_pct);
    drain();
    write_margin(margin);
    send_idle_pct = send_pct;
    recv_stall_pct = recv_pct;
    queue_random(PHASE_ITEMS);
  endtask

  initial begin
    clk = 1'b0;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    in_if.valid = 1'b0;
    in_if.mode = ffsa_pkg::MODE_ALLOC;
    in_if.request_size = '0;
    in_if.block_address = '0;
    out_if.ready = 1'b0;
    mismatches = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    reset_table();
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;

    // Directed items on the reset table with the reset margin.
    queue_request(ffsa_pkg::MODE_ALLOC, 0, 20'hFFFFF);     // zero size
    queue_request(ffsa_pkg::MODE_FREE, 1048576, 20'hFFFFF); // unknown address
    queue_request(ffsa_pkg::MODE_FREE, 0, 0);              // double free of the whole pool
    queue_request(ffsa_pkg::MODE_ALLOC, 1, 0);             // split off one byte
    queue_request(ffsa_pkg::MODE_ALLOC, 100, 0);
    queue_request(ffsa_pkg::MODE_FREE, 0, 1);
    queue_request(ffsa_pkg::MODE_FREE, 0, 1);              // double free
    queue_request(ffsa_pkg::MODE_ALLOC, 1, 0);             // split of a freed segment
    queue_request(ffsa_pkg::MODE_ALLOC, 1048576, 0);       // no segment long enough
    queue_request(ffsa_pkg::MODE_ALLOC, 99, 0);            // exact fit, no remainder
    queue_request(ffsa_pkg::MODE_FREE, 0, 2);
    queue_request(ffsa_pkg::MODE_ALLOC, 60, 0);            // leftover under margin: whole grant
    queue_request(ffsa_pkg::MODE_FREE, 0, 0);
    queue_request(ffsa_pkg::MODE_ALLOC, 2, 0);             // skips the one-byte segment
    queue_request(ffsa_pkg::MODE_FREE, 0, 20'h80000);
    queue_request(ffsa_pkg::MODE_ALLOC, 1, 20'hFFFFF);
    queue_request(ffsa_pkg::MODE_FREE, 0, 101);
    queue_request(ffsa_pkg::MODE_ALLOC, 1048575, 0);
    queue_request(ffsa_pkg::MODE_ALLOC, 524288, 20'h55555);
    queue_request(ffsa_pkg::MODE_FREE, 2097151 & 21'h0AAAAA, 20'hAAAAA);

    // Random phases: margin extremes first while the table still grows.
    run_phase(16'hFFFF, 0, 0);
    run_phase(16'h0000, 45, 0);
    run_phase(16'($urandom_range(65535)), 0, 45);
    run_phase(16'($urandom_range(65535)), 31, 31);
    run_phase(ffsa_pkg::MARGIN_RESET, 0, 0);
    drain();

    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
